[hdl/hsv_to_rgb_macros.svh]
// ----------------------------------------------------------------------------
// hsv_to_rgb assertion macros
// Simulation-only concurrent checks, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_MACROS_SVH
`define HSV_TO_RGB_MACROS_SVH

`ifndef SYNTHESIS

`define H2R_ASSERT(lbl, a_clk, a_rst_n, expr) \
  lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (expr)) \
    else $error("h2r check failed");

`define H2R_ASSERT_IMP(lbl, a_clk, a_rst_n, ante, cons) \
  lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
    else $error("h2r check failed");

`define H2R_ASSERT_NEXT(lbl, a_clk, a_rst_n, ante, cons) \
  lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
    else $error("h2r check failed");

`else

`define H2R_ASSERT(lbl, a_clk, a_rst_n, expr)

`define H2R_ASSERT_IMP(lbl, a_clk, a_rst_n, ante, cons)

`define H2R_ASSERT_NEXT(lbl, a_clk, a_rst_n, ante, cons)

`endif

`endif

[hdl/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// h2r_pkg
// Widths, constants, types and the channel clamp shared by the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package h2r_pkg;

  localparam int HUE_W  = 15;
  localparam int SV_W   = 9;
  localparam int CH_W   = 8;
  localparam int C_W    = 18;   // v*s
  localparam int Q_W    = 12;   // ramp position 0..3840
  localparam int M_W    = 20;   // v*256 - c, signed
  localparam int P_W    = 30;   // c*q
  localparam int N_W    = 32;   // numerator in 1/(65536*3840), signed
  localparam int W_W    = 37;   // 17*numerator, signed
  localparam int FRAC_W = 24;   // 255/(65536*3840) == 17/2^24
  localparam int CV_W   = 17;   // 255*v

  localparam int NUM_STAGES = 5;

  localparam logic [HUE_W-1:0] FULL_CIRCLE  = 15'd23040;
  localparam int               SECTOR_STEPS = 3840;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctrl_t;

  // floor(w / 2^24) clamped to 0..255
  function automatic logic [CH_W-1:0] chan_clamp(input logic signed [W_W-1:0] w);
    logic [CH_W-1:0] res;
    if (w[W_W-1] || (w == '0)) begin
      res = '0;
    end else if (|w[W_W-2:FRAC_W+CH_W]) begin
      res = '1;
    end else begin
      res = w[FRAC_W+CH_W-1:FRAC_W];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/h2r_ctrl.sv]
// ----------------------------------------------------------------------------
// h2r_ctrl
// Valid bits and per-stage load enables; bubbles collapse on output stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_rgb_macros.svh"

module h2r_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output h2r_pkg::pipe_ctrl_t      ctrl_o
);

  localparam int N = h2r_pkg::NUM_STAGES;

  logic [N-1:0] vld_r;
  logic [N-1:0] vld_nxt;
  logic [N:0]   rdy;
  logic [N-1:0] src;

  always_comb begin
    rdy[N] = out_ready;
    for (int i = N - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    src[0] = in_valid;
    for (int i = 1; i < N; i++) begin
      src[i] = vld_r[i-1];
    end
    for (int i = 0; i < N; i++) begin
      vld_nxt[i] = rdy[i] ? src[i] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctrl_o.load  = rdy[N-1:0] & src;
  assign ctrl_o.valid = vld_r;
  assign in_ready     = rdy[0];
  assign out_valid    = vld_r[N-1];

  `H2R_ASSERT_IMP(a_stall_full, clk, rst_n, !in_ready, &vld_r)
  `H2R_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, vld_r[0])
  `H2R_ASSERT_NEXT(a_drain_moves, clk, rst_n, out_valid && out_ready && !vld_r[N-2],
                   !out_valid)

endmodule

`default_nettype wire

[hdl/h2r_front.sv]
// ----------------------------------------------------------------------------
// h2r_front
// Stages 1-2: hue wrap, chroma product, sector split, ramp position, m term.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_rgb_macros.svh"

module h2r_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire h2r_pkg::pipe_ctrl_t                 ctrl_i,
  input  wire logic [h2r_pkg::HUE_W-1:0]           hue_i,
  input  wire logic [h2r_pkg::SV_W-1:0]            sat_i,
  input  wire logic [h2r_pkg::SV_W-1:0]            bri_i,
  output h2r_pkg::sector_t                         sec_o,
  output logic [h2r_pkg::Q_W-1:0]                  q_o,
  output logic [h2r_pkg::C_W-1:0]                  c_o,
  output logic signed [h2r_pkg::M_W-1:0]           m0_o,
  output logic [h2r_pkg::SV_W-1:0]                 v_o
);

  localparam int HW = h2r_pkg::HUE_W;
  localparam int SS = h2r_pkg::SECTOR_STEPS;
  localparam logic [HW-1:0] B1 = HW'(1 * SS);
  localparam logic [HW-1:0] B2 = HW'(2 * SS);
  localparam logic [HW-1:0] B3 = HW'(3 * SS);
  localparam logic [HW-1:0] B4 = HW'(4 * SS);
  localparam logic [HW-1:0] B5 = HW'(5 * SS);

  // stage 1
  logic [HW-1:0]               s1_hue_r, s1_hue_nxt;
  logic [h2r_pkg::C_W-1:0]     s1_c_r, s1_c_nxt;
  logic [h2r_pkg::SV_W-1:0]    s1_v_r;

  assign s1_hue_nxt = (hue_i >= h2r_pkg::FULL_CIRCLE) ? hue_i - h2r_pkg::FULL_CIRCLE : hue_i;
  assign s1_c_nxt   = h2r_pkg::C_W'(bri_i) * h2r_pkg::C_W'(sat_i);

  always_ff @(posedge clk) begin
    if (ctrl_i.load[0]) begin
      s1_hue_r <= s1_hue_nxt;
      s1_c_r   <= s1_c_nxt;
      s1_v_r   <= bri_i;
    end
  end

  // stage 2
  h2r_pkg::sector_t              s2_sec_r, s2_sec_nxt;
  logic [h2r_pkg::Q_W-1:0]       s2_q_r, s2_q_nxt;
  logic [h2r_pkg::C_W-1:0]       s2_c_r;
  logic signed [h2r_pkg::M_W-1:0] s2_m0_r, s2_m0_nxt;
  logic [h2r_pkg::SV_W-1:0]      s2_v_r;
  logic [HW-1:0]                 base;
  logic [HW-1:0]                 pos_full;
  logic [h2r_pkg::Q_W-1:0]       pos;

  always_comb begin
    if (s1_hue_r >= B5) begin
      s2_sec_nxt = h2r_pkg::SEC_MAG_RED;
      base       = B5;
    end else if (s1_hue_r >= B4) begin
      s2_sec_nxt = h2r_pkg::SEC_BLU_MAG;
      base       = B4;
    end else if (s1_hue_r >= B3) begin
      s2_sec_nxt = h2r_pkg::SEC_CYN_BLU;
      base       = B3;
    end else if (s1_hue_r >= B2) begin
      s2_sec_nxt = h2r_pkg::SEC_GRN_CYN;
      base       = B2;
    end else if (s1_hue_r >= B1) begin
      s2_sec_nxt = h2r_pkg::SEC_YEL_GRN;
      base       = B1;
    end else begin
      s2_sec_nxt = h2r_pkg::SEC_RED_YEL;
      base       = '0;
    end
    pos_full = s1_hue_r - base;
    pos      = pos_full[h2r_pkg::Q_W-1:0];
    // falling ramp in odd sectors
    s2_q_nxt = s2_sec_nxt[0] ? h2r_pkg::Q_W'(SS) - pos : pos;
  end

  assign s2_m0_nxt = $signed({3'b000, s1_v_r, 8'h00}) - $signed({2'b00, s1_c_r});

  always_ff @(posedge clk) begin
    if (ctrl_i.load[1]) begin
      s2_sec_r <= s2_sec_nxt;
      s2_q_r   <= s2_q_nxt;
      s2_c_r   <= s1_c_r;
      s2_m0_r  <= s2_m0_nxt;
      s2_v_r   <= s1_v_r;
    end
  end

  assign sec_o = s2_sec_r;
  assign q_o   = s2_q_r;
  assign c_o   = s2_c_r;
  assign m0_o  = s2_m0_r;
  assign v_o   = s2_v_r;

  `H2R_ASSERT_IMP(a_hue_wrapped, clk, rst_n, ctrl_i.valid[0],
                  s1_hue_r < h2r_pkg::FULL_CIRCLE)
  `H2R_ASSERT_IMP(a_ramp_range, clk, rst_n, ctrl_i.valid[1],
                  s2_q_r <= h2r_pkg::Q_W'(SS))
  `H2R_ASSERT_IMP(a_ramp_top_odd, clk, rst_n,
                  ctrl_i.valid[1] && (s2_q_r == h2r_pkg::Q_W'(SS)), s2_sec_r[0])

endmodule

`default_nettype wire

[hdl/h2r_back.sv]
// ----------------------------------------------------------------------------
// h2r_back
// Stages 3-5: ramp product, m scaling, channel scale/clamp, sector routing.
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_back (
  input  wire logic                                clk,
  input  wire h2r_pkg::pipe_ctrl_t                 ctrl_i,
  input  wire h2r_pkg::sector_t                    sec_i,
  input  wire logic [h2r_pkg::Q_W-1:0]             q_i,
  input  wire logic [h2r_pkg::C_W-1:0]             c_i,
  input  wire logic signed [h2r_pkg::M_W-1:0]      m0_i,
  input  wire logic [h2r_pkg::SV_W-1:0]            v_i,
  output logic [h2r_pkg::CH_W-1:0]                 red_o,
  output logic [h2r_pkg::CH_W-1:0]                 green_o,
  output logic [h2r_pkg::CH_W-1:0]                 blue_o
);

  localparam int PW = h2r_pkg::P_W;
  localparam int NW = h2r_pkg::N_W;
  localparam int WW = h2r_pkg::W_W;
  localparam int CW = h2r_pkg::CH_W;
  localparam int VW = h2r_pkg::CV_W;

  // stage 3: c*q and m*3840
  logic [PW-1:0]             s3_p_r, s3_p_nxt;
  logic signed [NW-1:0]      s3_mc_r, s3_mc_nxt;
  logic signed [NW-1:0]      m_ext;
  h2r_pkg::sector_t          s3_sec_r;
  logic [h2r_pkg::SV_W-1:0]  s3_v_r;

  assign s3_p_nxt  = PW'(c_i) * PW'(q_i);
  assign m_ext     = NW'(m0_i);
  assign s3_mc_nxt = (m_ext <<< 12) - (m_ext <<< 8);

  always_ff @(posedge clk) begin
    if (ctrl_i.load[2]) begin
      s3_p_r   <= s3_p_nxt;
      s3_mc_r  <= s3_mc_nxt;
      s3_sec_r <= sec_i;
      s3_v_r   <= v_i;
    end
  end

  // stage 4: ramp numerator, zero and full channels
  logic signed [NW-1:0]  s4_nx_r, s4_nx_nxt;
  logic [CW-1:0]         s4_zero_r, s4_zero_nxt;
  logic [CW-1:0]         s4_full_r, s4_full_nxt;
  h2r_pkg::sector_t      s4_sec_r;
  logic signed [WW-1:0]  m17;
  logic [VW-1:0]         cv;

  assign s4_nx_nxt   = $signed({2'b00, s3_p_r}) + s3_mc_r;
  assign m17         = WW'(s3_mc_r) + (WW'(s3_mc_r) <<< 4);
  assign s4_zero_nxt = h2r_pkg::chan_clamp(m17);
  // channel carrying c gets floor(255*v/256)
  assign cv          = {s3_v_r, 8'h00} - VW'(s3_v_r);
  assign s4_full_nxt = cv[VW-1] ? '1 : cv[VW-2:VW-1-CW];

  always_ff @(posedge clk) begin
    if (ctrl_i.load[3]) begin
      s4_nx_r   <= s4_nx_nxt;
      s4_zero_r <= s4_zero_nxt;
      s4_full_r <= s4_full_nxt;
      s4_sec_r  <= s3_sec_r;
    end
  end

  // stage 5: ramp channel and routing
  logic signed [WW-1:0]  x17;
  logic [CW-1:0]         xch;
  logic [CW-1:0]         red_r, red_nxt;
  logic [CW-1:0]         green_r, green_nxt;
  logic [CW-1:0]         blue_r, blue_nxt;

  assign x17 = WW'(s4_nx_r) + (WW'(s4_nx_r) <<< 4);
  assign xch = h2r_pkg::chan_clamp(x17);

  always_comb begin
    case (s4_sec_r)
      h2r_pkg::SEC_RED_YEL: begin
        red_nxt = s4_full_r; green_nxt = xch;       blue_nxt = s4_zero_r;
      end
      h2r_pkg::SEC_YEL_GRN: begin
        red_nxt = xch;       green_nxt = s4_full_r; blue_nxt = s4_zero_r;
      end
      h2r_pkg::SEC_GRN_CYN: begin
        red_nxt = s4_zero_r; green_nxt = s4_full_r; blue_nxt = xch;
      end
      h2r_pkg::SEC_CYN_BLU: begin
        red_nxt = s4_zero_r; green_nxt = xch;       blue_nxt = s4_full_r;
      end
      h2r_pkg::SEC_BLU_MAG: begin
        red_nxt = xch;       green_nxt = s4_zero_r; blue_nxt = s4_full_r;
      end
      default: begin
        red_nxt = s4_full_r; green_nxt = s4_zero_r; blue_nxt = xch;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.load[4]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;

endmodule

`default_nettype wire

[hdl/hsv_to_rgb.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb
// HSV to 8-bit RGB converter, five-stage pipeline.
//
//   channel | direction | handshake           | request fields
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid/in_ready   | hue, saturation, brightness
//   out     | output    | out_valid/out_ready | red, green, blue
//
// One request per cycle while the output is not stalled; out_valid is the last stage's valid bit.
// Depth is set by the chroma multiply, the c*q ramp multiply and the x17 scale.
// rst_n clears the stage valid bits only; data registers are not reset.
// A stalled output holds; empty stages upstream keep filling until all are full.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [h2r_pkg::HUE_W-1:0]  in_hue,
  input  wire logic [h2r_pkg::SV_W-1:0]   in_saturation,
  input  wire logic [h2r_pkg::SV_W-1:0]   in_brightness,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [h2r_pkg::CH_W-1:0]        out_red,
  output logic [h2r_pkg::CH_W-1:0]        out_green,
  output logic [h2r_pkg::CH_W-1:0]        out_blue
);

  h2r_pkg::pipe_ctrl_t               ctrl;
  h2r_pkg::sector_t                  sec;
  logic [h2r_pkg::Q_W-1:0]           q;
  logic [h2r_pkg::C_W-1:0]           c;
  logic signed [h2r_pkg::M_W-1:0]    m0;
  logic [h2r_pkg::SV_W-1:0]          v;

  h2r_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl_o    (ctrl)
  );

  h2r_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (ctrl),
    .hue_i  (in_hue),
    .sat_i  (in_saturation),
    .bri_i  (in_brightness),
    .sec_o  (sec),
    .q_o    (q),
    .c_o    (c),
    .m0_o   (m0),
    .v_o    (v)
  );

  h2r_back u_back (
    .clk     (clk),
    .ctrl_i  (ctrl),
    .sec_i   (sec),
    .q_i     (q),
    .c_i     (c),
    .m0_i    (m0),
    .v_i     (v),
    .red_o   (out_red),
    .green_o (out_green),
    .blue_o  (out_blue)
  );

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb testbench
// Sends HSV colour requests through the converter with random gaps on the
// request side and random stalls on the result side. An exact fixed point
// predictor works out each RGB result, which is checked in order against the
// converter's output. Covers sector edges, hue wrap, and saturation and
// brightness above 1.0.
// ----------------------------------------------------------------------------
module testbench;

  localparam longint UNIT_DEN = 64'd251658240;  // 65536 * 3840
  localparam int     N_RANDOM = 700;

  typedef struct {
    logic [h2r_pkg::HUE_W-1:0] hue;
    logic [h2r_pkg::SV_W-1:0]  sat;
    logic [h2r_pkg::SV_W-1:0]  val;
  } colour_req_t;

  typedef struct {
    colour_req_t              req;
    logic [h2r_pkg::CH_W-1:0] red;
    logic [h2r_pkg::CH_W-1:0] green;
    logic [h2r_pkg::CH_W-1:0] blue;
  } rgb_due_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [h2r_pkg::HUE_W-1:0] in_hue = '0;
  logic [h2r_pkg::SV_W-1:0]  in_saturation = '0;
  logic [h2r_pkg::SV_W-1:0]  in_brightness = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [h2r_pkg::CH_W-1:0]  out_red;
  logic [h2r_pkg::CH_W-1:0]  out_green;
  logic [h2r_pkg::CH_W-1:0]  out_blue;

  colour_req_t colour_reqs[$];
  rgb_due_t    rgb_due[$];
  logic        req_taken = 1'b0;
  logic        rsp_taken = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int          faults = 0;

  hsv_to_rgb i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // num is in units of 1/(65536*3840)
  function automatic logic [h2r_pkg::CH_W-1:0] channel_of(longint num);
    longint scaled;
    if (num <= 0) begin
      return '0;
    end
    scaled = (num * 255) / UNIT_DEN;
    if (scaled > 255) begin
      scaled = 255;
    end
    return scaled[h2r_pkg::CH_W-1:0];
  endfunction

  function automatic rgb_due_t rgb_of_hsv(colour_req_t req);
    rgb_due_t res;
    longint   h, s, v, sec, pos, c, cu, xu, mu, rn, gn, bn;
    h = longint'(req.hue);
    s = longint'(req.sat);
    v = longint'(req.val);
    if (h >= 23040) begin
      h = h - 23040;
    end
    sec = h / h2r_pkg::SECTOR_STEPS;
    pos = h % h2r_pkg::SECTOR_STEPS;
    c   = v * s;
    cu  = c * h2r_pkg::SECTOR_STEPS;
    xu  = sec[0] ? c * (h2r_pkg::SECTOR_STEPS - pos) : c * pos;
    mu  = (v * 256 - c) * h2r_pkg::SECTOR_STEPS;
    case (h2r_pkg::sector_t'(sec[2:0]))
      h2r_pkg::SEC_RED_YEL: begin rn = cu; gn = xu; bn = 0;  end
      h2r_pkg::SEC_YEL_GRN: begin rn = xu; gn = cu; bn = 0;  end
      h2r_pkg::SEC_GRN_CYN: begin rn = 0;  gn = cu; bn = xu; end
      h2r_pkg::SEC_CYN_BLU: begin rn = 0;  gn = xu; bn = cu; end
      h2r_pkg::SEC_BLU_MAG: begin rn = xu; gn = 0;  bn = cu; end
      default:              begin rn = cu; gn = 0;  bn = xu; end
    endcase
    res.req   = req;
    res.red   = channel_of(rn + mu);
    res.green = channel_of(gn + mu);
    res.blue  = channel_of(bn + mu);
    return res;
  endfunction

  task automatic note_fault(string msg);
    faults++;
    if (faults <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic add_req(int hue, int sat, int val);
    colour_req_t req;
    req.hue = hue[h2r_pkg::HUE_W-1:0];
    req.sat = sat[h2r_pkg::SV_W-1:0];
    req.val = val[h2r_pkg::SV_W-1:0];
    colour_reqs = {colour_reqs, req};
  endtask

  // request driver
  always @(negedge clk) begin : drive_requests
    colour_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // held until accepted
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (colour_reqs.size() > 0) begin
      nxt = colour_reqs.pop_front();
      in_hue        <= nxt.hue;
      in_saturation <= nxt.sat;
      in_brightness <= nxt.val;
      in_valid      <= 1'b1;
      if ($urandom_range(0, 39) == 0) begin
        in_calm = !in_calm;
      end
      gap_left <= in_calm ? 0 : $urandom_range(0, 4);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin : drive_ready
    int wait_n;
    wait_n = stall_left;
    if (rsp_taken) begin
      if ($urandom_range(0, 39) == 0) begin
        out_calm = !out_calm;
      end
      wait_n = out_calm ? 0 : $urandom_range(0, 4);
    end
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (wait_n > 0) begin
      out_ready  <= 1'b0;
      stall_left <= wait_n - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end
  end

  // request/result monitor and checker
  always @(posedge clk) begin : watch
    rgb_due_t due;
    if (!rst_n) begin
      req_taken <= 1'b0;
      rsp_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      rsp_taken <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        rgb_due = {rgb_due, rgb_of_hsv('{in_hue, in_saturation, in_brightness})};
      end
      if (out_valid && out_ready) begin
        if (rgb_due.size() == 0) begin
          note_fault($sformatf("unexpected result rgb=(%0d,%0d,%0d)",
                               out_red, out_green, out_blue));
        end else begin
          due = rgb_due.pop_front();
          if (out_red !== due.red || out_green !== due.green || out_blue !== due.blue) begin
            note_fault($sformatf(
              "hsv=(%0d,%0d,%0d) expected rgb=(%0d,%0d,%0d) got (%0d,%0d,%0d)",
              due.req.hue, due.req.sat, due.req.val, due.red, due.green, due.blue,
              out_red, out_green, out_blue));
          end
        end
      end
    end
  end

  initial begin : stimulus
    int k, pick, base;
    // primaries and sector edges
    add_req(0, 256, 256);
    add_req(3839, 256, 256);
    add_req(3840, 256, 256);
    add_req(7680, 256, 256);
    add_req(11519, 200, 200);
    add_req(11520, 256, 256);
    add_req(15360, 256, 256);
    add_req(19199, 256, 255);
    add_req(19200, 256, 256);
    add_req(23039, 256, 256);
    // hue wrap past a full turn
    add_req(23040, 256, 256);
    add_req(26880, 256, 256);
    add_req(32767, 511, 511);
    // grey, black and tiny values
    add_req(1920, 0, 256);
    add_req(5000, 256, 0);
    add_req(0, 0, 0);
    add_req(12345, 1, 1);
    // saturation and brightness beyond 1.0
    add_req(9000, 511, 256);
    add_req(14000, 128, 511);
    add_req(17000, 511, 511);
    add_req(2000, 300, 100);
    add_req(21000, 256, 256);

    for (k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        add_req($urandom_range(0, 32767), $urandom_range(0, 511), $urandom_range(0, 511));
      end else if (pick == 1) begin
        base = $urandom_range(0, 6) * h2r_pkg::SECTOR_STEPS;
        add_req(base + $urandom_range(0, 2) - 1 + (base == 0 ? 1 : 0),
                $urandom_range(0, 256), $urandom_range(0, 256));
      end else begin
        add_req($urandom_range(0, 23039), $urandom_range(0, 256), $urandom_range(0, 256));
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (colour_reqs.size() > 0 || in_valid) begin
      @(posedge clk);
    end
    while (rgb_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (rgb_due.size() > 0) begin
      note_fault($sformatf("%0d results never arrived", rgb_due.size()));
    end
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
